// File: rtl/page_frame_stack_allocator_macros.svh
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_macros
// Assertion macros used by the page frame stack allocator top level.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PFSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsa_pkg
// Types, operation and status codes, and constants of the page frame allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

    // Operation codes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_FREE  = 2'd1;
    localparam logic [1:0] STAT_MISALIGN = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_FREE = 2'd0;
    localparam logic [1:0] CFG_REGION_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_RAM    = 2'd2;

    // Configuration reset values
    localparam logic [31:0] FIRST_FREE_RST = 32'h0010_0000;
    localparam logic [31:0] REGION_LEN_RST = 32'h0000_0000;
    localparam logic [31:0] MAX_RAM_RST    = 32'h0800_0000;

    // Address constants
    localparam logic [31:0] REGION_BASE = 32'h0010_0000;
    localparam logic [31:0] PAGE_MASK   = 32'hffff_f000;
    localparam logic [31:0] OFFSET_MASK = 32'h0000_0fff;
    localparam logic [31:0] PAGE_BYTES  = 32'h0000_1000;

    // Field widths
    localparam int unsigned PAGE_NUM_W = 20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } pfsa_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic op_accept;
        logic walk_push;
        logic walk_done;
        logic load_out;
    } pfsa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_more;
    } pfsa_stat_t;

endpackage

// File: rtl/pfsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfsa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read port; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pfsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Sequencer: takes one transaction, runs the init walk for init, hands off the result.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           opcode,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfsa_pkg::pfsa_cmd_t  cmd,
    input  pfsa_pkg::pfsa_stat_t stat
);
    import pfsa_pkg::*;

    pfsa_state_t state_reg;
    pfsa_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op_accept = 1'b1;
                    state_next    = (opcode == OP_INIT) ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_more)
                begin
                    cmd.walk_push = 1'b1;
                end
                else
                begin
                    cmd.walk_done = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Wait for the output slot to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/pfsa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsa_dpath
// Datapath: configuration, stack pointer, init walk address, page RAM, result.
// ----------------------------------------------------------------------------
module pfsa_dpath #(
    parameter int MAX_PAGES = 32768
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [31:0]          cfg_wdata,
    input  logic [1:0]           opcode,
    input  logic [31:0]          free_addr,
    input  pfsa_pkg::pfsa_cmd_t  cmd,
    output pfsa_pkg::pfsa_stat_t stat,
    output logic [31:0]          page_addr,
    output logic [1:0]           status,
    output logic [15:0]          free_pages,
    output logic                 all_free
);
    import pfsa_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PAGES);
    localparam int TOP_W  = $clog2(MAX_PAGES + 1);

    // Configuration registers
    logic [31:0] first_free_reg;
    logic [31:0] region_len_reg;
    logic [31:0] max_ram_reg;

    // Stack state
    logic [TOP_W-1:0] stack_top_reg;
    logic [TOP_W-1:0] stack_top_next;
    logic [TOP_W-1:0] total_pages_reg;
    logic [TOP_W-1:0] total_pages_next;
    logic [TOP_W-1:0] top_dec;
    logic             stack_full;

    // Init walk
    logic [32:0] walk_addr_reg;
    logic [32:0] walk_addr_next;
    logic [32:0] limit_reg;
    logic [32:0] limit_next;
    logic [31:0] start_addr;

    // Pending result
    logic [1:0] pend_status_reg;
    logic [1:0] pend_status_next;
    logic       pend_pop_reg;
    logic       pend_pop_next;

    // Output register
    logic [31:0] page_addr_reg;
    logic [1:0]  status_reg;
    logic [15:0] free_pages_reg;
    logic        all_free_reg;

    // RAM ports
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [PAGE_NUM_W-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [PAGE_NUM_W-1:0] ram_rd_data;

    pfsa_ram #(
        .WIDTH (PAGE_NUM_W),
        .DEPTH (MAX_PAGES)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_free_reg <= FIRST_FREE_RST;
            region_len_reg <= REGION_LEN_RST;
            max_ram_reg    <= MAX_RAM_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_FIRST_FREE: first_free_reg <= cfg_wdata;
                CFG_REGION_LEN: region_len_reg <= cfg_wdata;
                CFG_MAX_RAM:    max_ram_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign stack_full = (stack_top_reg == TOP_W'(MAX_PAGES));
    assign top_dec    = stack_top_reg - TOP_W'(1);
    assign start_addr = (first_free_reg + PAGE_BYTES) & PAGE_MASK;

    // Walk continues while inside the region, at or below the RAM ceiling and not full
    assign stat.walk_more = (walk_addr_reg < limit_reg)
                          && (walk_addr_reg <= {1'b0, max_ram_reg})
                          && !stack_full;

    // Operation decode, walk step and RAM access
    always_comb
    begin
        stack_top_next   = stack_top_reg;
        total_pages_next = total_pages_reg;
        walk_addr_next   = walk_addr_reg;
        limit_next       = limit_reg;
        pend_status_next = pend_status_reg;
        pend_pop_next    = pend_pop_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = stack_top_reg[ADDR_W-1:0];
        ram_wr_data      = free_addr[31:12];
        ram_rd_en        = 1'b0;
        ram_rd_addr      = top_dec[ADDR_W-1:0];

        if (cmd.op_accept)
        begin
            pend_status_next = STAT_OK;
            pend_pop_next    = 1'b0;
            unique case (opcode)
                OP_INIT:
                begin
                    stack_top_next = '0;
                    walk_addr_next = {1'b0, start_addr};
                    limit_next     = {1'b0, REGION_BASE} + {1'b0, region_len_reg};
                end
                OP_ALLOC:
                begin
                    if (stack_top_reg == '0)
                    begin
                        pend_status_next = STAT_NO_FREE;
                    end
                    else
                    begin
                        ram_rd_en      = 1'b1;
                        stack_top_next = top_dec;
                        pend_pop_next  = 1'b1;
                    end
                end
                OP_FREE:
                begin
                    if ((free_addr & OFFSET_MASK) != '0)
                    begin
                        pend_status_next = STAT_MISALIGN;
                    end
                    else if (stack_full)
                    begin
                        pend_status_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_wr_en      = 1'b1;
                        stack_top_next = stack_top_reg + TOP_W'(1);
                    end
                end
                OP_NOP:
                begin
                    pend_status_next = STAT_OK;
                end
                default:
                begin
                    pend_status_next = STAT_OK;
                end
            endcase
        end
        else if (cmd.walk_push)
        begin
            ram_wr_en      = 1'b1;
            ram_wr_data    = walk_addr_reg[31:12];
            stack_top_next = stack_top_reg + TOP_W'(1);
            walk_addr_next = walk_addr_reg + {1'b0, PAGE_BYTES};
        end
        else if (cmd.walk_done)
        begin
            total_pages_next = stack_top_reg;
        end
    end

    // Stack pointer and init count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg   <= '0;
            total_pages_reg <= '0;
        end
        else
        begin
            stack_top_reg   <= stack_top_next;
            total_pages_reg <= total_pages_next;
        end
    end

    // Walk and pending-result payload
    always_ff @(posedge clk)
    begin
        walk_addr_reg   <= walk_addr_next;
        limit_reg       <= limit_next;
        pend_status_reg <= pend_status_next;
        pend_pop_reg    <= pend_pop_next;
    end

    // Load the output register when the slot frees up
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            page_addr_reg  <= pend_pop_reg ? {ram_rd_data, 12'h000} : 32'h0;
            status_reg     <= pend_status_reg;
            free_pages_reg <= 16'(stack_top_reg);
            all_free_reg   <= (stack_top_reg >= total_pages_reg);
        end
    end

    assign page_addr  = page_addr_reg;
    assign status     = status_reg;
    assign free_pages = free_pages_reg;
    assign all_free   = all_free_reg;

endmodule

// File: rtl/page_frame_stack_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_stack_allocator
// Stack of free 4 KiB page frames with init, alloc, free and no-op operations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (opcode, free_addr); each request
//   yields exactly one result on the m_axis channel (page_addr, status,
//   free_pages, all_free). Registers are written through cfg_wr_en, cfg_addr
//   and cfg_wdata; the user must write them only while no transaction is
//   in flight, as the block itself does not enforce it. Alloc, free and
//   no-op results pass through the pending-result registers and then the
//   output register. Init pushes at most MAX_PAGES pages, bounded by the
//   single write port of the stack RAM, one page per cycle. One transaction
//   is processed at a time; the next request is taken the cycle after the
//   result loads. A result waiting in the output register does not block
//   the next request, but the request after it waits until the receiver
//   takes it. Reset empties the stack, clears the init count and restores
//   the configuration defaults; the stack RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "page_frame_stack_allocator_macros.svh"

module page_frame_stack_allocator #(
    parameter int MAX_PAGES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] opcode, [33:2] free_addr, zero fill
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [31:0] page_addr, [33:32] status,
                                        // [49:34] free_pages, [50] all_free, zero fill
);
    import pfsa_pkg::*;

    pfsa_cmd_t   cmd;
    pfsa_stat_t  stat;
    logic [31:0] page_addr;
    logic [1:0]  status;
    logic [15:0] free_pages;
    logic        all_free;
    logic        in_fire;
    logic        cmd_busy;

    pfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .opcode    (s_axis_tdata[1:0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pfsa_dpath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .opcode     (s_axis_tdata[1:0]),
        .free_addr  (s_axis_tdata[33:2]),
        .cmd        (cmd),
        .stat       (stat),
        .page_addr  (page_addr),
        .status     (status),
        .free_pages (free_pages),
        .all_free   (all_free)
    );

    // Pack the result
    assign m_axis_tdata = {5'b0, all_free, free_pages, status, page_addr};

    // Request accept and the commands that must not meet it
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cmd_busy = cmd.walk_push || cmd.walk_done || cmd.load_out;

    // One transaction at a time: no request is taken right after another
    `PFSA_ASSERT_NEXT(a_one_in_flight, in_fire, !s_axis_tready, "request accepted back to back")
    // Loading a result always raises the result valid
    `PFSA_ASSERT_NEXT(a_load_shows, cmd.load_out, m_axis_tvalid, "loaded result not presented")
    // Accept never coincides with a walk step or a result load
    `PFSA_ASSERT_NOW(a_cmd_excl, cmd.op_accept, !cmd_busy, "conflicting commands")

endmodule
